// ===== rtl/rthb_pkg.sv =====
// Shared types, constants and the function-code table of the HID report builder.
package rthb_pkg;

  localparam int RING_DEPTH = 32;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int NUM_SLOTS  = 6;
  localparam int OUT_DEPTH  = 4;
  localparam int OUT_AW     = $clog2(OUT_DEPTH);

  localparam logic [1:0] CMD_KEY     = 2'd0;
  localparam logic [1:0] CMD_BUTTON  = 2'd1;
  localparam logic [1:0] CMD_MOTION  = 2'd2;
  localparam logic [1:0] CMD_SERVICE = 2'd3;

  localparam logic [1:0] BTN_LEFT   = 2'd1;
  localparam logic [1:0] BTN_RIGHT  = 2'd2;
  localparam logic [1:0] BTN_MIDDLE = 2'd3;

  localparam logic       REPORT_KB    = 1'b0;
  localparam logic       REPORT_MOUSE = 1'b1;

  localparam logic [7:0] FC_RELEASE_ALL = 8'hFF;
  localparam logic signed [15:0] STEP_MAX = 16'sd127;
  localparam logic signed [15:0] STEP_MIN = -16'sd127;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [7:0]        function_code;
    logic              release_flag;
    logic              btn_press;
    logic [1:0]        button_code;
    logic signed [7:0] move_x;
    logic signed [7:0] move_y;
    logic              host_mounted;
    logic              host_ready;
  } in_item_t;

  typedef struct packed {
    logic              report_kind;
    logic [7:0]        modifier_mask;
    logic [7:0]        key_slot_0;
    logic [7:0]        key_slot_1;
    logic [7:0]        key_slot_2;
    logic [7:0]        key_slot_3;
    logic [7:0]        key_slot_4;
    logic [7:0]        key_slot_5;
    logic [2:0]        button_mask;
    logic signed [7:0] step_x;
    logic signed [7:0] step_y;
    logic              last_result;
  } out_item_t;

  typedef struct packed {
    logic [7:0]                  mods;
    logic [NUM_SLOTS-1:0][7:0]   keys;
  } kb_state_t;

  localparam int KB_W = $bits(kb_state_t);

  typedef struct packed {
    logic               we;
    logic [RING_AW-1:0] waddr;
    kb_state_t          wdata;
    logic [RING_AW-1:0] raddr;
  } ring_req_t;

  typedef struct packed {
    logic [1:0] n;
    out_item_t  item0;
    out_item_t  item1;
  } emit_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] usage;
    logic [7:0] modbit;
  } rom_entry_t;

  function automatic logic [RING_AW-1:0] ring_inc(input logic [RING_AW-1:0] p);
    return (p == RING_AW'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic signed [7:0] clamp_step(input logic signed [15:0] v);
    if (v > STEP_MAX) return 8'sd127;
    if (v < STEP_MIN) return -8'sd127;
    return v[7:0];
  endfunction

  function automatic rom_entry_t rom_lookup(input logic [7:0] fc);
    rom_entry_t r;
    r = '{hit: 1'b1, usage: 8'h00, modbit: 8'h00};
    case (fc)
      8'h02: r.usage = 8'h05;  8'h03: r.usage = 8'h2B;  8'h04: r.usage = 8'h4F;
      8'h05: r.usage = 8'h2C;  8'h06: r.usage = 8'h34;  8'h07: r.modbit = 8'h02;
      8'h08: r.usage = 8'h2E;  8'h09: r.usage = 8'h2F;  8'h0B: r.usage = 8'h28;
      8'h0C: r.usage = 8'h29;  8'h0D: r.usage = 8'h50;  8'h12: r.usage = 8'h04;
      8'h13: r.usage = 8'h16;  8'h14: r.usage = 8'h07;  8'h15: r.usage = 8'h09;
      8'h16: r.usage = 8'h0D;  8'h18: r.usage = 8'h0E;  8'h19: r.usage = 8'h0F;
      8'h1B: r.usage = 8'h33;  8'h1C: r.usage = 8'h4E;  8'h1D: r.usage = 8'h4D;
      8'h1E: r.modbit = 8'h08; 8'h21: r.modbit = 8'h40; 8'h22: r.usage = 8'h14;
      8'h23: r.usage = 8'h1A;  8'h24: r.usage = 8'h08;  8'h25: r.usage = 8'h15;
      8'h26: r.usage = 8'h18;  8'h28: r.usage = 8'h0C;  8'h29: r.usage = 8'h12;
      8'h2B: r.usage = 8'h13;  8'h32: r.usage = 8'h1D;  8'h33: r.usage = 8'h1B;
      8'h34: r.usage = 8'h06;  8'h35: r.usage = 8'h19;  8'h36: r.usage = 8'h10;
      8'h37: r.modbit = 8'h20; 8'h38: r.usage = 8'h36;  8'h39: r.usage = 8'h37;
      8'h3B: r.usage = 8'h38;  8'h3C: r.usage = 8'h31;  8'h3D: r.usage = 8'h11;
      8'h41: r.usage = 8'h4F;  8'h42: r.usage = 8'h3C;  8'h43: r.usage = 8'h29;
      8'h44: r.usage = 8'h3E;  8'h45: r.usage = 8'h22;  8'h46: r.usage = 8'h23;
      8'h48: r.usage = 8'h3F;  8'h49: r.usage = 8'h41;  8'h4C: r.usage = 8'h2A;
      8'h4D: r.usage = 8'h4A;  8'h4E: r.usage = 8'h31;  8'h52: r.usage = 8'h3B;
      8'h53: r.usage = 8'h3A;  8'h54: r.usage = 8'h3D;  8'h55: r.usage = 8'h0A;
      8'h56: r.usage = 8'h0B;  8'h58: r.usage = 8'h40;  8'h59: r.usage = 8'h42;
      8'h5C: r.usage = 8'h52;  8'h5D: r.usage = 8'h4B;  8'h5F: r.modbit = 8'h01;
      8'h62: r.usage = 8'h1E;  8'h63: r.usage = 8'h1F;  8'h64: r.usage = 8'h20;
      8'h65: r.usage = 8'h21;  8'h66: r.usage = 8'h24;  8'h68: r.usage = 8'h25;
      8'h69: r.usage = 8'h26;  8'h6B: r.usage = 8'h27;  8'h6C: r.usage = 8'h51;
      8'h6D: r.usage = 8'h4C;  8'h71: r.modbit = 8'h04; 8'h72: r.usage = 8'h35;
      8'h73: r.usage = 8'h39;  8'h75: r.usage = 8'h17;  8'h76: r.usage = 8'h1C;
      8'h78: r.usage = 8'h44;  8'h79: r.usage = 8'h43;  8'h7B: r.usage = 8'h45;
      8'h7C: r.usage = 8'h46;
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/rthb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rthb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/rthb_out_fifo.sv =====
// Result queue: takes up to two report items per cycle, hands out one.
module rthb_out_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  rthb_pkg::emit_t     emit,
  output logic                space_ok,
  output logic                out_valid,
  input  logic                out_ready,
  output rthb_pkg::out_item_t out_item
);
  import rthb_pkg::*;

  out_item_t          q_r [OUT_DEPTH];
  logic [OUT_AW-1:0]  wptr_r, rptr_r;
  logic [OUT_AW:0]    cnt_r;
  logic [OUT_AW-1:0]  wptr_nxt, rptr_nxt;
  logic [OUT_AW:0]    cnt_nxt;
  logic               pop;

  assign out_valid = (cnt_r != '0);
  assign out_item  = q_r[rptr_r];
  assign space_ok  = (cnt_r <= (OUT_AW+1)'(OUT_DEPTH - 2));
  assign pop       = out_valid && out_ready;

  always_comb begin
    wptr_nxt = wptr_r + OUT_AW'(emit.n);
    rptr_nxt = pop ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r + (OUT_AW+1)'(emit.n) - (OUT_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.n != 2'd0) begin
      q_r[wptr_r] <= emit.item0;
    end
    if (emit.n == 2'd2) begin
      q_r[wptr_r + 1'b1] <= emit.item1;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (OUT_AW+1)'(OUT_DEPTH))
    else $error("result queue count beyond depth");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    emit.n != 2'd0 |-> space_ok)
    else $error("report items pushed without room");

  a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && emit.n == 2'd0) |=> cnt_r == $past(cnt_r) - 1'b1)
    else $error("queue count did not drop on pop");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    emit.n == 2'd2 |-> (!emit.item0.last_result && emit.item1.last_result))
    else $error("last_result misplaced in item pair");

endmodule

// ===== rtl/rthb_core.sv =====
// Key, button, motion and service processing with all builder state.
module rthb_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rthb_pkg::in_item_t  in_item,
  input  logic                space_ok,
  output rthb_pkg::emit_t     emit,
  output rthb_pkg::ring_req_t ring_req,
  input  rthb_pkg::kb_state_t ring_rdata
);
  import rthb_pkg::*;

  typedef enum logic [2:0] {
    PH_MAIN   = 3'b001,
    PH_SECOND = 3'b010,
    PH_READ   = 3'b100
  } phase_t;

  in_item_t           in_r;
  logic               v_r;
  phase_t             phase_r, phase_nxt;
  kb_state_t          kb_r, kb_nxt, last_r, last_nxt;
  logic [RING_AW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [2:0]         btn_r, btn_nxt;
  logic [15:0]        pdx_r, pdx_nxt, pdy_r, pdy_nxt;
  logic               mpend_r, mpend_nxt, mb_r, mb_nxt;

  logic               adv, finish, ready_host, push_req, mouse_try, dup, lost;
  kb_state_t          push_val;
  rom_entry_t         rom;
  logic [7:0]         new_mods, sx5, sy5, dx8, dy8;
  logic               found, free_found;
  logic [2:0]         found_idx, free_idx;
  logic signed [7:0]  stx, sty;
  out_item_t          mouse_item;

  assign ready_host = in_r.host_mounted && in_r.host_ready;
  assign adv        = v_r && space_ok;
  assign in_ready   = !v_r || finish;
  assign rom        = rom_lookup(in_r.function_code);

  always_comb begin
    found      = 1'b0;
    free_found = 1'b0;
    found_idx  = '0;
    free_idx   = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (kb_r.keys[i] == rom.usage) begin
        found     = 1'b1;
        found_idx = 3'(i);
      end
      if (kb_r.keys[i] == 8'h00) begin
        free_found = 1'b1;
        free_idx   = 3'(i);
      end
    end
  end

  // wrap the x5 scaling to 8 bits; y is inverted
  assign sx5 = in_r.move_x + {in_r.move_x[5:0], 2'b00};
  assign sy5 = in_r.move_y + {in_r.move_y[5:0], 2'b00};
  assign dx8 = sx5;
  assign dy8 = 8'h00 - sy5;

  always_comb begin
    phase_nxt = phase_r;
    kb_nxt    = kb_r;
    last_nxt  = last_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    btn_nxt   = btn_r;
    pdx_nxt   = pdx_r;
    pdy_nxt   = pdy_r;
    mpend_nxt = mpend_r;
    mb_nxt    = mb_r;
    finish    = 1'b0;
    push_req  = 1'b0;
    push_val  = kb_r;
    mouse_try = 1'b0;
    lost      = 1'b0;
    new_mods  = kb_r.mods;
    dup       = 1'b0;
    stx       = '0;
    sty       = '0;
    mouse_item = '0;
    emit      = '0;
    ring_req  = '0;
    ring_req.raddr = head_r;

    if (adv) begin
      case (phase_r)
        PH_MAIN: begin
          finish = 1'b1;
          case (in_r.cmd)
            CMD_KEY: begin
              if (in_r.function_code == FC_RELEASE_ALL) begin
                kb_nxt   = '0;
                push_req = 1'b1;
                push_val = '0;
              end else if (rom.hit) begin
                if (rom.modbit != 8'h00) begin
                  new_mods = in_r.release_flag ? (kb_r.mods & ~rom.modbit)
                                               : (kb_r.mods | rom.modbit);
                  if (new_mods != kb_r.mods) begin
                    kb_nxt.mods   = new_mods;
                    push_req      = 1'b1;
                    push_val.mods = new_mods;
                  end
                end else if (in_r.release_flag) begin
                  if (found) begin
                    kb_nxt.keys[found_idx] = 8'h00;
                    push_req = 1'b1;
                    push_val = kb_nxt;
                  end else if (free_found) begin
                    // tap: push pressed state now, released state in PH_SECOND
                    push_req = 1'b1;
                    push_val.keys[free_idx] = rom.usage;
                    phase_nxt = PH_SECOND;
                    finish    = 1'b0;
                  end
                end else if (!found && free_found) begin
                  kb_nxt.keys[free_idx] = rom.usage;
                  push_req = 1'b1;
                  push_val = kb_nxt;
                end
              end
            end
            CMD_BUTTON: begin
              if (in_r.btn_press) begin
                case (in_r.button_code)
                  BTN_LEFT:   btn_nxt = btn_r | 3'b001;
                  BTN_RIGHT:  btn_nxt = btn_r | 3'b010;
                  BTN_MIDDLE: btn_nxt = btn_r | 3'b100;
                  default:    btn_nxt = btn_r;
                endcase
              end else begin
                btn_nxt = '0;
              end
              mpend_nxt = 1'b1;
              mouse_try = 1'b1;
            end
            CMD_MOTION: begin
              pdx_nxt   = pdx_r + {{8{dx8[7]}}, dx8};
              pdy_nxt   = pdy_r + {{8{dy8[7]}}, dy8};
              mpend_nxt = 1'b1;
              mouse_try = 1'b1;
            end
            default: begin
              lost = mb_r && !in_r.host_mounted;
              if (lost) begin
                kb_nxt    = '0;
                head_nxt  = '0;
                tail_nxt  = '0;
                btn_nxt   = '0;
                pdx_nxt   = '0;
                pdy_nxt   = '0;
                mpend_nxt = 1'b0;
              end
              mb_nxt = in_r.host_mounted;
              if (!lost && head_r != tail_r && ready_host) begin
                // fetch the oldest entry; report it in PH_READ
                phase_nxt = PH_READ;
                finish    = 1'b0;
              end else begin
                mouse_try = 1'b1;
              end
            end
          endcase
        end
        PH_SECOND: begin
          push_req  = 1'b1;
          push_val  = kb_r;
          phase_nxt = PH_MAIN;
          finish    = 1'b1;
        end
        PH_READ: begin
          emit.n                   = 2'd1;
          emit.item0.report_kind   = REPORT_KB;
          emit.item0.modifier_mask = ring_rdata.mods;
          emit.item0.key_slot_0    = ring_rdata.keys[0];
          emit.item0.key_slot_1    = ring_rdata.keys[1];
          emit.item0.key_slot_2    = ring_rdata.keys[2];
          emit.item0.key_slot_3    = ring_rdata.keys[3];
          emit.item0.key_slot_4    = ring_rdata.keys[4];
          emit.item0.key_slot_5    = ring_rdata.keys[5];
          head_nxt  = ring_inc(head_r);
          mouse_try = 1'b1;
          phase_nxt = PH_MAIN;
          finish    = 1'b1;
        end
        default: phase_nxt = PH_MAIN;
      endcase
    end

    if (mouse_try && mpend_nxt && ready_host) begin
      stx = clamp_step(pdx_nxt);
      sty = clamp_step(pdy_nxt);
      mouse_item.report_kind = REPORT_MOUSE;
      mouse_item.button_mask = btn_nxt;
      mouse_item.step_x      = stx;
      mouse_item.step_y      = sty;
      pdx_nxt   = pdx_nxt - {{8{stx[7]}}, stx};
      pdy_nxt   = pdy_nxt - {{8{sty[7]}}, sty};
      mpend_nxt = (pdx_nxt != '0) || (pdy_nxt != '0);
      if (emit.n == 2'd0) begin
        emit.item0 = mouse_item;
      end else begin
        emit.item1 = mouse_item;
      end
      emit.n = emit.n + 2'd1;
    end

    if (emit.n == 2'd1) begin
      emit.item0.last_result = 1'b1;
    end else if (emit.n == 2'd2) begin
      emit.item1.last_result = 1'b1;
    end

    // drop an exact repeat of the newest entry; overwrite oldest when full
    if (push_req) begin
      dup = (head_r != tail_r) && (push_val == last_r);
      if (!dup) begin
        ring_req.we    = 1'b1;
        ring_req.waddr = tail_r;
        ring_req.wdata = push_val;
        tail_nxt       = ring_inc(tail_r);
        if (ring_inc(tail_r) == head_r) begin
          head_nxt = ring_inc(head_r);
        end
        last_nxt = push_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r     <= 1'b0;
      phase_r <= PH_MAIN;
      kb_r    <= '0;
      head_r  <= '0;
      tail_r  <= '0;
      btn_r   <= '0;
      pdx_r   <= '0;
      pdy_r   <= '0;
      mpend_r <= 1'b0;
      mb_r    <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        v_r <= 1'b1;
      end else if (finish) begin
        v_r <= 1'b0;
      end
      phase_r <= phase_nxt;
      kb_r    <= kb_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      btn_r   <= btn_nxt;
      pdx_r   <= pdx_nxt;
      pdy_r   <= pdy_nxt;
      mpend_r <= mpend_nxt;
      mb_r    <= mb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_item;
    end
    last_r <= last_nxt;
  end

endmodule

// ===== rtl/remote_to_hid_report_builder.sv =====
// Top level of the remote-control to HID keyboard and mouse report builder.
// An item is normally finished as soon as it is processed in the working register
// and its reports then sit in a four-entry result queue, so a new item is accepted
// every cycle while results wait, as long as the queue has room for two. Two cases
// hold an item for an extra step: a key tap (release of a key not held), which
// writes two entries into the 32-entry report ring through its single write port,
// and a service tick that sends a keyboard report, which waits for the ring's registered read.
// An item is processed only when the result queue has room for two reports;
// until then it holds in the working register and the input stalls.
module remote_to_hid_report_builder (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rthb_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output rthb_pkg::out_item_t out_item
);
  import rthb_pkg::*;

  emit_t     emit;
  ring_req_t ring_req;
  kb_state_t ring_rdata;
  logic      space_ok;

  rthb_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .space_ok   (space_ok),
    .emit       (emit),
    .ring_req   (ring_req),
    .ring_rdata (ring_rdata)
  );

  rthb_ram #(
    .WIDTH (KB_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ring_req.we),
    .waddr (ring_req.waddr),
    .wdata (ring_req.wdata),
    .raddr (ring_req.raddr),
    .rdata (ring_rdata)
  );

  rthb_out_fifo u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .emit      (emit),
    .space_ok  (space_ok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

// ===== sim/tb_remote_to_hid_report_builder.sv =====
// Testbench for the remote-control to HID report builder: predicted reports checked in order.
`timescale 1ns / 1ps

module tb_remote_to_hid_report_builder;
  import rthb_pkg::*;

  class report_board;
    out_item_t pending_reports[$];
    int errors;
    logic [7:0] keys [6];
    logic [7:0] mods;
    logic [55:0] ring [32];
    int head, tail;
    logic [2:0] btns;
    logic [15:0] acc_dx, acc_dy;
    bit mouse_due, host_seen;

    function void clear_state();
      foreach (keys[i]) keys[i] = 8'h00;
      mods = 8'h00; head = 0; tail = 0; btns = 3'b000;
      acc_dx = 16'h0; acc_dy = 16'h0; mouse_due = 0;
    endfunction

    function new();
      errors = 0; host_seen = 0;
      clear_state();
      foreach (ring[i]) ring[i] = '0;
    endfunction

    function logic [55:0] kb_now();
      return {mods, keys[0], keys[1], keys[2], keys[3], keys[4], keys[5]};
    endfunction

    function void push_kb();
      logic [55:0] s;
      int nt;
      s = kb_now();
      if (head != tail && ring[(tail + 31) % 32] == s) return;
      nt = (tail + 1) % 32;
      if (nt == head) head = (head + 1) % 32;
      ring[tail] = s;
      tail = nt;
    endfunction

    function int slot_of(logic [7:0] u);
      for (int i = 0; i < 6; i++) if (keys[i] == u) return i;
      return -1;
    endfunction

    function bit add_key(logic [7:0] u);
      int i;
      if (u == 0 || slot_of(u) >= 0) return 0;
      i = slot_of(8'h00);
      if (i < 0) return 0;
      keys[i] = u;
      return 1;
    endfunction

    function bit drop_key(logic [7:0] u);
      int i;
      if (u == 0) return 0;
      i = slot_of(u);
      if (i < 0) return 0;
      keys[i] = 8'h00;
      return 1;
    endfunction

    // code table: {usage, modifier bit}, zero pair means unknown
    function logic [15:0] lookup(logic [7:0] fc);
      case (fc)
        8'h02: return 16'h0500; 8'h03: return 16'h2B00; 8'h04: return 16'h4F00;
        8'h05: return 16'h2C00; 8'h06: return 16'h3400; 8'h07: return 16'h0002;
        8'h08: return 16'h2E00; 8'h09: return 16'h2F00; 8'h0B: return 16'h2800;
        8'h0C: return 16'h2900; 8'h0D: return 16'h5000; 8'h12: return 16'h0400;
        8'h13: return 16'h1600; 8'h14: return 16'h0700; 8'h15: return 16'h0900;
        8'h16: return 16'h0D00; 8'h18: return 16'h0E00; 8'h19: return 16'h0F00;
        8'h1B: return 16'h3300; 8'h1C: return 16'h4E00; 8'h1D: return 16'h4D00;
        8'h1E: return 16'h0008; 8'h21: return 16'h0040; 8'h22: return 16'h1400;
        8'h23: return 16'h1A00; 8'h24: return 16'h0800; 8'h25: return 16'h1500;
        8'h26: return 16'h1800; 8'h28: return 16'h0C00; 8'h29: return 16'h1200;
        8'h2B: return 16'h1300; 8'h32: return 16'h1D00; 8'h33: return 16'h1B00;
        8'h34: return 16'h0600; 8'h35: return 16'h1900; 8'h36: return 16'h1000;
        8'h37: return 16'h0020; 8'h38: return 16'h3600; 8'h39: return 16'h3700;
        8'h3B: return 16'h3800; 8'h3C: return 16'h3100; 8'h3D: return 16'h1100;
        8'h41: return 16'h4F00; 8'h42: return 16'h3C00; 8'h43: return 16'h2900;
        8'h44: return 16'h3E00; 8'h45: return 16'h2200; 8'h46: return 16'h2300;
        8'h48: return 16'h3F00; 8'h49: return 16'h4100; 8'h4C: return 16'h2A00;
        8'h4D: return 16'h4A00; 8'h4E: return 16'h3100; 8'h52: return 16'h3B00;
        8'h53: return 16'h3A00; 8'h54: return 16'h3D00; 8'h55: return 16'h0A00;
        8'h56: return 16'h0B00; 8'h58: return 16'h4000; 8'h59: return 16'h4200;
        8'h5C: return 16'h5200; 8'h5D: return 16'h4B00; 8'h5F: return 16'h0001;
        8'h62: return 16'h1E00; 8'h63: return 16'h1F00; 8'h64: return 16'h2000;
        8'h65: return 16'h2100; 8'h66: return 16'h2400; 8'h68: return 16'h2500;
        8'h69: return 16'h2600; 8'h6B: return 16'h2700; 8'h6C: return 16'h5100;
        8'h6D: return 16'h4C00; 8'h71: return 16'h0004; 8'h72: return 16'h3500;
        8'h73: return 16'h3900; 8'h75: return 16'h1700; 8'h76: return 16'h1C00;
        8'h78: return 16'h4400; 8'h79: return 16'h4300; 8'h7B: return 16'h4500;
        8'h7C: return 16'h4600;
        default: return 16'h0000;
      endcase
    endfunction

    function logic signed [7:0] clip(logic signed [15:0] v);
      if (v > 16'sd127) return 8'sd127;
      if (v < -16'sd127) return -8'sd127;
      return v[7:0];
    endfunction

    function void mouse_report(bit ready);
      out_item_t r;
      if (!mouse_due || !ready) return;
      r = '0;
      r.report_kind = REPORT_MOUSE;
      r.button_mask = btns;
      r.step_x = clip(acc_dx);
      r.step_y = clip(acc_dy);
      acc_dx = acc_dx - {{8{r.step_x[7]}}, r.step_x};
      acc_dy = acc_dy - {{8{r.step_y[7]}}, r.step_y};
      mouse_due = (acc_dx != 0) || (acc_dy != 0);
      pending_reports.push_back(r);
    endfunction

    function void key_event(logic [7:0] fc, bit rel);
      logic [15:0] e;
      logic [7:0] nm;
      if (fc == FC_RELEASE_ALL) begin
        mods = 8'h00;
        foreach (keys[i]) keys[i] = 8'h00;
        push_kb();
        return;
      end
      e = lookup(fc);
      if (e == 0) return;
      if (e[7:0] != 0) begin
        nm = rel ? (mods & ~e[7:0]) : (mods | e[7:0]);
        if (nm != mods) begin
          mods = nm;
          push_kb();
        end
        return;
      end
      if (rel) begin
        if (drop_key(e[15:8])) push_kb();
        else if (add_key(e[15:8])) begin
          push_kb();
          void'(drop_key(e[15:8]));
          push_kb();
        end
      end else if (add_key(e[15:8])) push_kb();
    endfunction

    function void note_input(in_item_t it);
      bit ready;
      int n0;
      logic signed [7:0] sx, sy;
      out_item_t r;
      ready = it.host_mounted && it.host_ready;
      n0 = pending_reports.size();
      case (it.cmd)
        CMD_KEY: key_event(it.function_code, it.release_flag);
        CMD_BUTTON: begin
          if (it.btn_press) begin
            if (it.button_code == BTN_LEFT) btns[0] = 1'b1;
            else if (it.button_code == BTN_RIGHT) btns[1] = 1'b1;
            else if (it.button_code == BTN_MIDDLE) btns[2] = 1'b1;
          end else btns = 3'b000;
          mouse_due = 1;
          mouse_report(ready);
        end
        CMD_MOTION: begin
          sx = it.move_x * 8'sd5;
          sy = -(it.move_y * 8'sd5);
          acc_dx = acc_dx + {{8{sx[7]}}, sx};
          acc_dy = acc_dy + {{8{sy[7]}}, sy};
          mouse_due = 1;
          mouse_report(ready);
        end
        default: begin
          if (host_seen && !it.host_mounted) clear_state();
          host_seen = it.host_mounted;
          if (head != tail && ready) begin
            r = '0;
            r.report_kind = REPORT_KB;
            {r.modifier_mask, r.key_slot_0, r.key_slot_1, r.key_slot_2,
             r.key_slot_3, r.key_slot_4, r.key_slot_5} = ring[head];
            head = (head + 1) % 32;
            pending_reports.push_back(r);
          end
          mouse_report(ready);
        end
      endcase
      if (pending_reports.size() > n0)
        pending_reports[pending_reports.size() - 1].last_result = 1'b1;
    endfunction

    function void report(string what);
      $display("mismatch: %s at %0t", what, $realtime);
      errors++;
    endfunction

    function void check_result(out_item_t got);
      out_item_t w;
      if (pending_reports.size() == 0) begin
        report("report with none expected");
        return;
      end
      w = pending_reports.pop_front();
      if (got.report_kind != w.report_kind) report("report_kind");
      if (got.modifier_mask != w.modifier_mask) report("modifier_mask");
      if (got.key_slot_0 != w.key_slot_0) report("key_slot_0");
      if (got.key_slot_1 != w.key_slot_1) report("key_slot_1");
      if (got.key_slot_2 != w.key_slot_2) report("key_slot_2");
      if (got.key_slot_3 != w.key_slot_3) report("key_slot_3");
      if (got.key_slot_4 != w.key_slot_4) report("key_slot_4");
      if (got.key_slot_5 != w.key_slot_5) report("key_slot_5");
      if (got.button_mask != w.button_mask) report("button_mask");
      if (got.step_x != w.step_x) report("step_x");
      if (got.step_y != w.step_y) report("step_y");
      if (got.last_result != w.last_result) report("last_result");
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_item;

  report_board board = new();
  bit calm = 0;
  bit hold_off = 0;
  bit stall_go = 0;

  remote_to_hid_report_builder u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) board.note_input(in_item);
    if (rst_n && out_valid && out_ready) board.check_result(out_item);
  end

  always @(posedge clk) begin
    if (!rst_n || hold_off) out_ready <= 1'b0;
    else out_ready <= calm || ($urandom_range(99) >= 29);
  end

  // hold off the receiver for a long stretch while the sender keeps offering
  initial begin
    wait (stall_go);
    hold_off = 1;
    repeat (200) @(posedge clk);
    hold_off = 0;
  end

  // codes that are in the table (keys and modifiers), for well-formed presses and releases
  function logic [7:0] pick_key();
    logic [7:0] fc;
    do fc = 8'($urandom_range(8'h02, 8'h7C)); while (board.lookup(fc) == 0);
    return fc;
  endfunction

  function in_item_t random_item();
    in_item_t it;
    int r;
    it = in_item_t'($urandom());
    r = $urandom_range(99);
    if (r < 45) begin
      it.cmd = CMD_KEY;
      if ($urandom_range(9) < 8) it.function_code = pick_key();
      else if ($urandom_range(3) == 0) it.function_code = FC_RELEASE_ALL;
    end else if (r < 55) it.cmd = CMD_BUTTON;
    else if (r < 70) it.cmd = CMD_MOTION;
    else it.cmd = CMD_SERVICE;
    if ($urandom_range(9) < 8) it.host_mounted = 1'b1;
    if ($urandom_range(9) < 7) it.host_ready = 1'b1;
    return it;
  endfunction

  task automatic send(in_item_t it);
    if (!calm) begin
      while ($urandom_range(99) < 29) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_item <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_fields(logic [1:0] c, logic [7:0] fc, bit rel, bit bd,
                             logic [1:0] bc, logic [7:0] mx, logic [7:0] my,
                             bit mnt, bit rdy);
    in_item_t it;
    it = '{cmd: c, function_code: fc, release_flag: rel, btn_press: bd,
           button_code: bc, move_x: mx, move_y: my, host_mounted: mnt,
           host_ready: rdy};
    send(it);
  endtask

  initial begin
    int k;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: modifiers, slots filling, taps, unknown code, clear, mouse extremes
    send_fields(CMD_KEY, 8'h07, 0, 0, 0, 0, 0, 1, 1);
    send_fields(CMD_KEY, 8'h07, 0, 0, 0, 0, 0, 1, 1);
    send_fields(CMD_KEY, 8'h02, 0, 0, 0, 0, 0, 1, 1);
    send_fields(CMD_KEY, 8'h02, 0, 0, 0, 0, 0, 1, 1);
    send_fields(CMD_KEY, 8'h03, 0, 0, 0, 0, 0, 1, 1);
    send_fields(CMD_KEY, 8'h04, 0, 0, 0, 0, 0, 1, 1);
    send_fields(CMD_KEY, 8'h05, 0, 0, 0, 0, 0, 1, 1);
    send_fields(CMD_KEY, 8'h06, 0, 0, 0, 0, 0, 1, 1);
    send_fields(CMD_KEY, 8'h08, 0, 0, 0, 0, 0, 1, 1);
    send_fields(CMD_KEY, 8'h09, 0, 0, 0, 0, 0, 1, 1);
    send_fields(CMD_KEY, 8'h0B, 1, 0, 0, 0, 0, 1, 1);
    send_fields(CMD_KEY, 8'h02, 1, 0, 0, 0, 0, 1, 1);
    send_fields(CMD_KEY, 8'h0B, 1, 0, 0, 0, 0, 1, 1);
    send_fields(CMD_KEY, 8'h00, 0, 1, 3, 0, 0, 1, 1);
    send_fields(CMD_KEY, FC_RELEASE_ALL, 1, 0, 0, 0, 0, 1, 1);
    send_fields(CMD_BUTTON, 0, 0, 1, BTN_LEFT, 0, 0, 1, 1);
    send_fields(CMD_BUTTON, 0, 0, 1, 2'd0, 0, 0, 1, 1);
    send_fields(CMD_BUTTON, 0, 0, 1, BTN_MIDDLE, 0, 0, 1, 0);
    send_fields(CMD_MOTION, 0, 0, 0, 0, 8'h80, 8'h7F, 1, 1);
    send_fields(CMD_MOTION, 0, 0, 0, 0, 8'h7F, 8'h80, 0, 1);
    send_fields(CMD_SERVICE, 0, 0, 0, 0, 0, 0, 1, 1);
    send_fields(CMD_SERVICE, 0, 0, 0, 0, 0, 0, 1, 1);
    send_fields(CMD_BUTTON, 0, 0, 0, BTN_RIGHT, 0, 0, 1, 1);
    send_fields(CMD_SERVICE, 0, 0, 0, 0, 0, 0, 0, 0);
    send_fields(CMD_SERVICE, 0, 0, 0, 0, 0, 0, 1, 1);
    // random
    for (k = 0; k < 1350; k++) begin
      if (k == 300) calm = 1;
      if (k == 500) calm = 0;
      if (k == 700) stall_go = 1;
      send(random_item());
    end
    in_valid <= 1'b0;
    calm = 1;
    k = 0;
    while (board.pending_reports.size() != 0 && k < 5000) begin
      @(posedge clk);
      k++;
    end
    repeat (20) @(posedge clk);
    if (board.errors == 0 && board.pending_reports.size() == 0)
      $display("[remote_to_hid_report_builder] OK");
    else
      $display("[remote_to_hid_report_builder] ERROR");
    $finish;
  end

  initial begin
    #2000000;
    $display("[remote_to_hid_report_builder] ERROR");
    $finish;
  end

endmodule
